[hw/rtl/psqe_pkg.sv]
// ----------------------------------------------------------------------------
// psqe_pkg
// Shared types, widths, register codes and constants of the packed
// symmetric equilibration core.
// ----------------------------------------------------------------------------
package psqe_pkg;

	// Field widths fixed by the beat formats.
	localparam int SCALE_W     = 32;
	localparam int ELEM_W      = 32;
	localparam int ORDER_W     = 7;
	localparam int SCOND_W     = 17;
	localparam int SCALE_IDX_W = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	// Defaults for the top-level parameters.
	localparam int MAX_ORDER_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;

	// scond is Q1.16; the test scond < 0.1 is done exactly as scond * 10 < 1.0.
	localparam int SCOND_PROD_W = SCOND_W + 4;
	localparam int SCOND_ONE    = 65536;
	localparam int SCOND_TENTH  = 10;

	// Register reset values.
	localparam logic [SCOND_W-1:0] SCOND_RST     = SCOND_W'(65536);
	localparam logic [31:0]        AMAX_RST      = 32'h0001_0000;
	localparam logic [31:0]        AMAX_LOW_RST  = 32'h0000_0001;
	localparam logic [31:0]        AMAX_HIGH_RST = 32'hFFFF_FFFF;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOWER_MODE = 3'd0,
		CFG_ORDER      = 3'd1,
		CFG_SCOND      = 3'd2,
		CFG_AMAX       = 3'd3,
		CFG_AMAX_LOW   = 3'd4,
		CFG_AMAX_HIGH  = 3'd5
	} cfg_reg_t;

	// Beat kinds on the input side.
	localparam logic REQ_SCALE = 1'b0;
	localparam logic REQ_ELEM  = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_RND_P,
		ST_MUL_E,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/psqe_scale_mem.sv]
// ----------------------------------------------------------------------------
// psqe_scale_mem
// Scale factor store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module psqe_scale_mem #(
	parameter int DEPTH = psqe_pkg::MAX_ORDER_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [psqe_pkg::SCALE_W-1:0]  wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr_a,
	input  logic [AW-1:0]                 rd_addr_b,
	output logic [psqe_pkg::SCALE_W-1:0]  rd_data_a,
	output logic [psqe_pkg::SCALE_W-1:0]  rd_data_b
);

	logic [psqe_pkg::SCALE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds between reads so the arithmetic behind it sees a stable value.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

[hw/rtl/psqe_pos.sv]
// ----------------------------------------------------------------------------
// psqe_pos
// Row and column tracker for packed triangle order, upper or lower.
// ----------------------------------------------------------------------------
module psqe_pos #(
	parameter int MAX_ORDER = psqe_pkg::MAX_ORDER_DEF,
	parameter int CNT_LIM   = (MAX_ORDER < 128) ? MAX_ORDER : 128,
	parameter int CW        = (CNT_LIM > 1) ? $clog2(CNT_LIM) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          lower,
	input  logic [psqe_pkg::ORDER_W-1:0]  n,
	input  logic                          step,
	output logic [CW-1:0]                 pos_c,
	output logic [CW-1:0]                 pos_r,
	output logic                          pos_last
);

	logic [CW-1:0]                col_q, row_q;
	logic [CW-1:0]                col_nx, row_nx;
	logic [psqe_pkg::ORDER_W-1:0] c_ext, r_ext, nm1;
	logic                         bad;

	always_comb begin
		nm1 = n - 1'b1;
		// A position that does not fit the current order and mode restarts at the first one.
		bad = (psqe_pkg::ORDER_W'(col_q) >= n) || (psqe_pkg::ORDER_W'(row_q) >= n) ||
			(lower ? (row_q < col_q) : (row_q > col_q));
		pos_c = bad ? '0 : col_q;
		pos_r = bad ? '0 : row_q;
		c_ext = psqe_pkg::ORDER_W'(pos_c);
		r_ext = psqe_pkg::ORDER_W'(pos_r);
		pos_last = (c_ext == nm1) && (lower ? (r_ext == nm1) : (pos_r == pos_c));

		if (n == '0 || pos_last) begin
			col_nx = '0;
			row_nx = '0;
		end else if (lower) begin
			if (r_ext == nm1) begin
				col_nx = CW'(pos_c + 1'b1);
				row_nx = CW'(pos_c + 1'b1);
			end else begin
				col_nx = pos_c;
				row_nx = CW'(pos_r + 1'b1);
			end
		end else begin
			if (pos_r == pos_c) begin
				col_nx = CW'(pos_c + 1'b1);
				row_nx = '0;
			end else begin
				col_nx = pos_c;
				row_nx = CW'(pos_r + 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			col_q <= col_nx;
			row_q <= row_nx;
		end
	end

endmodule

[hw/rtl/psqe_scaler.sv]
// ----------------------------------------------------------------------------
// psqe_scaler
// Fixed-point scaling pipeline: s[col]*s[row], round and clip, then times
// each part of the entry, round half away from zero and clip.
// ----------------------------------------------------------------------------
module psqe_scaler #(
	parameter int FRAC_BITS = psqe_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic        [psqe_pkg::SCALE_W-1:0] scale_a,
	input  logic        [psqe_pkg::SCALE_W-1:0] scale_b,
	input  logic signed [psqe_pkg::ELEM_W-1:0]  elem_re,
	input  logic signed [psqe_pkg::ELEM_W-1:0]  elem_im,
	output logic signed [psqe_pkg::ELEM_W-1:0]  res_re,
	output logic signed [psqe_pkg::ELEM_W-1:0]  res_im,
	output logic                                res_sat
);

	localparam int PW = 2 * psqe_pkg::SCALE_W;
	localparam logic [PW:0] RND = (PW + 1)'(1) << (FRAC_BITS - 1);

	logic [PW-1:0]                p_full_s1;
	logic [psqe_pkg::SCALE_W-1:0] p_s2;
	logic                         psat_s2;
	logic [PW-1:0]                prod_re_s3, prod_im_s3;

	logic [PW:0]                  p_rnd;
	logic [psqe_pkg::ELEM_W-1:0]  mag_re, mag_im;
	logic [psqe_pkg::ELEM_W:0]    fin_re, fin_im;

	// Returns {clipped, value} for one rounded magnitude and its sign.
	function automatic logic [psqe_pkg::ELEM_W:0] finish(input logic neg,
			input logic [PW-1:0] prod);
		logic [PW:0]                 r;
		logic [psqe_pkg::ELEM_W-1:0] v;
		logic                        s;
		r = ({1'b0, prod} + RND) >> FRAC_BITS;
		s = 1'b0;
		if (neg) begin
			if (r > (PW + 1)'(33'h0_8000_0000)) begin
				s = 1'b1;
				v = 32'h8000_0000;
			end else begin
				v = 32'd0 - r[psqe_pkg::ELEM_W-1:0];
			end
		end else begin
			if (r > (PW + 1)'(33'h0_7FFF_FFFF)) begin
				s = 1'b1;
				v = 32'h7FFF_FFFF;
			end else begin
				v = r[psqe_pkg::ELEM_W-1:0];
			end
		end
		return {s, v};
	endfunction

	always_comb begin
		p_rnd  = ({1'b0, p_full_s1} + RND) >> FRAC_BITS;
		mag_re = elem_re[psqe_pkg::ELEM_W-1] ? (32'd0 - elem_re) : elem_re;
		mag_im = elem_im[psqe_pkg::ELEM_W-1] ? (32'd0 - elem_im) : elem_im;
		fin_re = finish(elem_re[psqe_pkg::ELEM_W-1], prod_re_s3);
		fin_im = finish(elem_im[psqe_pkg::ELEM_W-1], prod_im_s3);
	end

	always_ff @(posedge clk) begin
		p_full_s1 <= PW'(scale_a) * PW'(scale_b);
		if (p_rnd > (PW + 1)'(33'h0_FFFF_FFFF)) begin
			p_s2    <= 32'hFFFF_FFFF;
			psat_s2 <= 1'b1;
		end else begin
			p_s2    <= p_rnd[psqe_pkg::SCALE_W-1:0];
			psat_s2 <= 1'b0;
		end
		prod_re_s3 <= PW'(mag_re) * PW'(p_s2);
		prod_im_s3 <= PW'(mag_im) * PW'(p_s2);
	end

	assign res_re  = fin_re[psqe_pkg::ELEM_W-1:0];
	assign res_im  = fin_im[psqe_pkg::ELEM_W-1:0];
	assign res_sat = psat_s2 | fin_re[psqe_pkg::ELEM_W] | fin_im[psqe_pkg::ELEM_W];

endmodule

[hw/rtl/packed_symmetric_equilibrate_core.sv]
// ----------------------------------------------------------------------------
// packed_symmetric_equilibrate_core
// Equilibration of a complex symmetric matrix in packed storage, fixed point.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Beat contents (lowest bits first)
// s_*       in   tuser: req_type; tdata: scale_index, scale_value, elem_re, elem_im
// m_*       out  tuser: equilibrated, saturated; tdata: out_re, out_im; tlast: last
// cfg_*     in   one register write per cycle with cfg_we high, no read-back
//
// A scale load yields no result. A matrix entry either passes through or is
// scaled; when it is scaled, the store read, the scale product, its rounding,
// the entry products and the final rounding run one after another. The block
// works on one entry at a time; a finished result sits in the output register
// so the next beat can be taken while the result waits. Reset returns the
// control state and configuration registers to their defaults; the scale store
// and the data registers hold no reset value. While the output register holds
// a result and m_tready is low, a finished entry stays in the last step until
// the output register frees up.
//
module packed_symmetric_equilibrate_core #(
	parameter int MAX_ORDER = psqe_pkg::MAX_ORDER_DEF,
	parameter int FRAC_BITS = psqe_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [5:0] scale_index, [37:6] scale_value, [69:38] elem_re, [101:70] elem_im
	input  logic [103:0]                     s_tdata,
	// [0] req_type
	input  logic [0:0]                       s_tuser,

	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] out_re, [63:32] out_im
	output logic [63:0]                      m_tdata,
	// [0] equilibrated, [1] saturated
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast,

	input  logic                             cfg_we,
	input  logic [psqe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psqe_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int CNT_LIM = (MAX_ORDER < 128) ? MAX_ORDER : 128;
	localparam int CW      = (CNT_LIM > 1) ? $clog2(CNT_LIM) : 1;

	// Input beat fields.
	logic                                 in_req_type;
	logic [psqe_pkg::SCALE_IDX_W-1:0]     in_scale_index;
	logic [psqe_pkg::SCALE_W-1:0]         in_scale_value;
	logic signed [psqe_pkg::ELEM_W-1:0]   in_elem_re, in_elem_im;

	assign in_req_type    = s_tuser[0];
	assign in_scale_index = s_tdata[5:0];
	assign in_scale_value = s_tdata[37:6];
	assign in_elem_re     = s_tdata[69:38];
	assign in_elem_im     = s_tdata[101:70];

	// Configuration registers.
	logic                             lower_mode_q;
	logic [psqe_pkg::ORDER_W-1:0]     order_q;
	logic [psqe_pkg::SCOND_W-1:0]     scond_q;
	logic [31:0]                      amax_q, amax_low_q, amax_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_mode_q <= 1'b0;
			order_q      <= '0;
			scond_q      <= psqe_pkg::SCOND_RST;
			amax_q       <= psqe_pkg::AMAX_RST;
			amax_low_q   <= psqe_pkg::AMAX_LOW_RST;
			amax_high_q  <= psqe_pkg::AMAX_HIGH_RST;
		end else if (cfg_we) begin
			case (psqe_pkg::cfg_reg_t'(cfg_index))
				psqe_pkg::CFG_LOWER_MODE: lower_mode_q <= cfg_data[0];
				psqe_pkg::CFG_ORDER:      order_q      <= cfg_data[psqe_pkg::ORDER_W-1:0];
				psqe_pkg::CFG_SCOND:      scond_q      <= cfg_data[psqe_pkg::SCOND_W-1:0];
				psqe_pkg::CFG_AMAX:       amax_q       <= cfg_data;
				psqe_pkg::CFG_AMAX_LOW:   amax_low_q   <= cfg_data;
				psqe_pkg::CFG_AMAX_HIGH:  amax_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The order in use is clamped to the store depth.
	logic [psqe_pkg::ORDER_W-1:0] n_eff;
	logic                         n_zero;
	logic                         equil_now;

	always_comb begin
		n_eff  = (32'(order_q) > MAX_ORDER) ? psqe_pkg::ORDER_W'(MAX_ORDER) : order_q;
		n_zero = (n_eff == '0);
		// Scaling is needed when scond < 0.1 or amax leaves its window.
		equil_now = ((psqe_pkg::SCOND_PROD_W'(scond_q) *
			psqe_pkg::SCOND_PROD_W'(psqe_pkg::SCOND_TENTH)) <
			psqe_pkg::SCOND_PROD_W'(psqe_pkg::SCOND_ONE)) ||
			(amax_q < amax_low_q) || (amax_q > amax_high_q);
	end

	// Sequencer.
	psqe_pkg::state_t state_q, state_nx;
	logic             accept, accept_elem, accept_scale, out_load;

	assign accept       = s_tvalid && s_tready;
	assign accept_elem  = accept && (in_req_type == psqe_pkg::REQ_ELEM);
	assign accept_scale = accept && (in_req_type == psqe_pkg::REQ_SCALE);

	// Entry state captured when the beat is taken.
	logic signed [psqe_pkg::ELEM_W-1:0] elem_re_q, elem_im_q;
	logic                               equil_q, last_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			psqe_pkg::ST_IDLE: begin
				if (accept_elem) begin
					state_nx = (equil_now && !n_zero) ? psqe_pkg::ST_MUL_P : psqe_pkg::ST_DONE;
				end
			end
			psqe_pkg::ST_MUL_P: state_nx = psqe_pkg::ST_RND_P;
			psqe_pkg::ST_RND_P: state_nx = psqe_pkg::ST_MUL_E;
			psqe_pkg::ST_MUL_E: state_nx = psqe_pkg::ST_DONE;
			psqe_pkg::ST_DONE: begin
				if (out_load) begin
					state_nx = psqe_pkg::ST_IDLE;
				end
			end
			default: state_nx = psqe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			psqe_pkg::ST_IDLE: s_tready = 1'b1;
			psqe_pkg::ST_DONE: out_load = !m_tvalid || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psqe_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Position tracking.
	logic [CW-1:0] pos_c, pos_r;
	logic          pos_last;

	psqe_pos #(
		.MAX_ORDER (MAX_ORDER)
	) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.lower    (lower_mode_q),
		.n        (n_eff),
		.step     (accept_elem),
		.pos_c    (pos_c),
		.pos_r    (pos_r),
		.pos_last (pos_last)
	);

	// Scale store: loads write it, entries read both of their factors at once.
	logic                         scale_ok;
	logic [psqe_pkg::SCALE_W-1:0] s_col, s_row;

	assign scale_ok = (32'(in_scale_index) < MAX_ORDER);

	psqe_scale_mem #(
		.DEPTH (MAX_ORDER),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (accept_scale && scale_ok),
		.wr_addr   (AW'(in_scale_index)),
		.wr_data   (in_scale_value),
		.rd_en     (accept_elem),
		.rd_addr_a (AW'(pos_c)),
		.rd_addr_b (AW'(pos_r)),
		.rd_data_a (s_col),
		.rd_data_b (s_row)
	);

	always_ff @(posedge clk) begin
		if (accept_elem) begin
			elem_re_q <= in_elem_re;
			elem_im_q <= in_elem_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			equil_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (accept_elem) begin
			// Order zero passes every entry through as the last of its matrix.
			equil_q <= equil_now && !n_zero;
			last_q  <= n_zero || pos_last;
		end
	end

	// Arithmetic: the element registers hold still while the pipeline fills.
	logic signed [psqe_pkg::ELEM_W-1:0] res_re, res_im;
	logic                               res_sat;

	psqe_scaler #(
		.FRAC_BITS (FRAC_BITS)
	) u_scaler (
		.clk     (clk),
		.scale_a (s_col),
		.scale_b (s_row),
		.elem_re (elem_re_q),
		.elem_im (elem_im_q),
		.res_re  (res_re),
		.res_im  (res_im),
		.res_sat (res_sat)
	);

	// Output register.
	logic                               m_valid_q;
	logic signed [psqe_pkg::ELEM_W-1:0] out_re_q, out_im_q;
	logic                               out_equil_q, out_sat_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_re_q    <= equil_q ? res_re : elem_re_q;
			out_im_q    <= equil_q ? res_im : elem_im_q;
			out_equil_q <= equil_q;
			out_sat_q   <= equil_q && res_sat;
			out_last_q  <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {out_im_q, out_re_q};
	assign m_tuser  = {out_sat_q, out_equil_q};
	assign m_tlast  = out_last_q;

endmodule
